@@ src/bmh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared types and codes for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmh_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_PUSH_START,
        OP_ERR_FULL,
        OP_ERR_EMPTY,
        OP_RD_PARENT,
        OP_CLIMB,
        OP_WRITE_HOLE,
        OP_RD_ENDS,
        OP_POP_LOAD,
        OP_RD_CHILDREN,
        OP_SINK,
        OP_RD_TOP,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic req_pop;
        logic full;
        logic empty;
        logic at_root;
        logic has_left;
        logic move_up;
        logic move_down;
        logic out_free;
    } dp_stat_t;

endpackage

@@ src/binary_max_heap_priority_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_top
// Binary max-heap of signed 32-bit values with push and pop-maximum requests.
// ----------------------------------------------------------------------------
// One request is worked at a time. A push climbs and a pop sinks up to L levels,
// where L is at most log2(CAPACITY); each level is a RAM read followed by a
// compare-and-write on the heap RAM, whose two read ports fetch both children
// at once. Errors (pop on empty, push on full) skip the heap walk. A finished
// result waits in the output register while the next request is accepted.
// Entries are kept in a RAM with no reset; only the fill count and the output
// valid flag are cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_top import bmh_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // [31:0] popped_value, [63:32] top_value,
                                   // [64] is_empty, [75:65] entry_count,
                                   // [77:76] error_code, [79:78] zero
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    logic signed [DATA_W-1:0] out_popped, out_top;
    logic                     out_empty;
    logic [COUNT_W-1:0]       out_count;
    logic [1:0]               out_err;

    bmh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bmh_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_req     (s_tuser[0]),
        .in_value   ($signed(s_tdata)),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_popped (out_popped),
        .out_top    (out_top),
        .out_empty  (out_empty),
        .out_count  (out_count),
        .out_err    (out_err)
    );

    assign m_tdata = {2'b00, out_err, out_count, out_empty, out_top, out_popped};

endmodule

@@ src/bmh_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re_a,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic             re_b,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re_a) begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b) begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

@@ src/bmh_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_dp
// Heap datapath: fill count, sift index, moving value, heap RAM, result register.
// ----------------------------------------------------------------------------
module bmh_dp import bmh_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic                     in_req,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic                     m_tready,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] out_popped,
    output logic signed [DATA_W-1:0] out_top,
    output logic                     out_empty,
    output logic [COUNT_W-1:0]       out_count,
    output logic [1:0]               out_err
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ov_reg, ov_next;

    logic [CW-1:0]             k_reg, k_next;
    logic                      req_reg, req_next;
    logic signed [DATA_W-1:0]  val_reg, val_next;
    logic signed [DATA_W-1:0]  popped_reg, popped_next;
    err_t                      err_reg, err_next;

    logic signed [DATA_W-1:0]  opop_reg, otop_reg;
    logic                      oempty_reg;
    logic [COUNT_W-1:0]        ocount_reg;
    err_t                      oerr_reg;

    logic              we, re_a, re_b;
    logic [AW-1:0]     waddr, raddr_a, raddr_b;
    logic [DATA_W-1:0] wdata, rdata_a, rdata_b;
    logic signed [DATA_W-1:0] rd_a, rd_b;

    logic [CW:0]       k2, cnt_w;
    logic [CW-1:0]     parent, child_idx;
    logic [AW-1:0]     addr_k, addr_parent, addr_left, addr_right, addr_last;
    logic              has_left, has_right, right_wins, move_up, move_down, empty;
    logic signed [DATA_W-1:0] child_val;
    logic [CW+COUNT_W-1:0] cnt_ext;

    assign rd_a  = $signed(rdata_a);
    assign rd_b  = $signed(rdata_b);
    assign k2    = {k_reg, 1'b0};
    assign cnt_w = {1'b0, cnt_reg};
    assign parent = k_reg >> 1;

    assign addr_k      = AW'(k_reg - 1'b1);
    assign addr_parent = AW'(parent - 1'b1);
    assign addr_left   = AW'(k2 - 1'b1);
    assign addr_right  = AW'(k2);
    assign addr_last   = AW'(cnt_reg - 1'b1);

    assign has_left   = (k2 <= cnt_w);
    assign has_right  = ((k2 + 1'b1) <= cnt_w);
    assign right_wins = has_right && (rd_a < rd_b);
    assign child_val  = right_wins ? rd_b : rd_a;
    assign child_idx  = right_wins ? CW'(k2 + 1'b1) : CW'(k2);
    assign move_up    = (rd_a < val_reg);
    assign move_down  = (val_reg < child_val);
    assign empty      = (cnt_reg == '0);
    assign cnt_ext    = {{COUNT_W{1'b0}}, cnt_reg};

    assign stat.req_pop   = req_reg;
    assign stat.full      = (cnt_reg == CW'(CAPACITY));
    assign stat.empty     = empty;
    assign stat.at_root   = (k_reg == CW'(1));
    assign stat.has_left  = has_left;
    assign stat.move_up   = move_up;
    assign stat.move_down = move_down;
    assign stat.out_free  = !ov_reg || m_tready;

    always_comb begin
        cnt_next    = cnt_reg;
        ov_next     = ov_reg && !m_tready;
        k_next      = k_reg;
        req_next    = req_reg;
        val_next    = val_reg;
        popped_next = popped_reg;
        err_next    = err_reg;
        we          = 1'b0;
        waddr       = addr_k;
        wdata       = val_reg;
        re_a        = 1'b0;
        raddr_a     = '0;
        re_b        = 1'b0;
        raddr_b     = addr_last;
        case (cmd.op)
            OP_TAKE: begin
                req_next    = in_req;
                val_next    = in_value;
                err_next    = ERR_OK;
                popped_next = '0;
            end
            OP_PUSH_START: begin
                cnt_next = cnt_reg + 1'b1;
                k_next   = cnt_reg + 1'b1;
            end
            OP_ERR_FULL: begin
                err_next = ERR_FULL;
            end
            OP_ERR_EMPTY: begin
                err_next = ERR_EMPTY;
            end
            OP_RD_PARENT: begin
                re_a    = 1'b1;
                raddr_a = addr_parent;
            end
            OP_CLIMB: begin
                we = 1'b1;
                if (move_up) begin
                    wdata  = rdata_a;
                    k_next = parent;
                end
            end
            OP_WRITE_HOLE: begin
                we = 1'b1;
            end
            OP_RD_ENDS: begin
                re_a    = 1'b1;
                raddr_a = '0;
                re_b    = 1'b1;
                raddr_b = addr_last;
            end
            OP_POP_LOAD: begin
                popped_next = rd_a;
                val_next    = rd_b;
                cnt_next    = cnt_reg - 1'b1;
                k_next      = CW'(1);
            end
            OP_RD_CHILDREN: begin
                re_a    = 1'b1;
                raddr_a = addr_left;
                re_b    = 1'b1;
                raddr_b = addr_right;
            end
            OP_SINK: begin
                we = 1'b1;
                if (move_down) begin
                    wdata  = child_val;
                    k_next = child_idx;
                end
            end
            OP_RD_TOP: begin
                re_a    = 1'b1;
                raddr_a = '0;
            end
            OP_EMIT: begin
                ov_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        req_reg    <= req_next;
        val_reg    <= val_next;
        popped_reg <= popped_next;
        err_reg    <= err_next;
        if (cmd.op == OP_EMIT) begin
            opop_reg   <= popped_reg;
            otop_reg   <= empty ? '0 : rd_a;
            oempty_reg <= empty;
            ocount_reg <= cnt_ext[COUNT_W-1:0];
            oerr_reg   <= err_reg;
        end
    end

    bmh_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re_a    (re_a),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .re_b    (re_b),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    assign out_valid  = ov_reg;
    assign out_popped = opop_reg;
    assign out_top    = otop_reg;
    assign out_empty  = oempty_reg;
    assign out_count  = ocount_reg;
    assign out_err    = oerr_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_err_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && oerr_reg == ERR_EMPTY) |-> (oempty_reg && opop_reg == '0))
        else $error("pop on empty heap reported a value");

    a_err_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && oerr_reg == ERR_FULL) |-> (!oempty_reg && opop_reg == '0))
        else $error("full heap reported as empty");

    a_sink_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_SINK && move_down) |=> (k_reg > $past(k_reg)))
        else $error("sift-down did not descend");

endmodule

@@ src/bmh_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_ctrl
// Sequencer for push sift-up, pop sift-down and result hand-off.
// ----------------------------------------------------------------------------
module bmh_ctrl import bmh_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_PUSH_CHK,
        ST_PUSH_CMP,
        ST_POP_LD,
        ST_SINK_CHK,
        ST_SINK_CMP,
        ST_TOP_RD,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_TAKE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (!stat.req_pop) begin
                    if (stat.full) begin
                        cmd.op     = OP_ERR_FULL;
                        state_next = ST_TOP_RD;
                    end else begin
                        cmd.op     = OP_PUSH_START;
                        state_next = ST_PUSH_CHK;
                    end
                end else if (stat.empty) begin
                    cmd.op     = OP_ERR_EMPTY;
                    state_next = ST_TOP_RD;
                end else begin
                    cmd.op     = OP_RD_ENDS;
                    state_next = ST_POP_LD;
                end
            end
            ST_PUSH_CHK: begin
                if (stat.at_root) begin
                    cmd.op     = OP_WRITE_HOLE;
                    state_next = ST_TOP_RD;
                end else begin
                    cmd.op     = OP_RD_PARENT;
                    state_next = ST_PUSH_CMP;
                end
            end
            ST_PUSH_CMP: begin
                cmd.op     = OP_CLIMB;
                state_next = stat.move_up ? ST_PUSH_CHK : ST_TOP_RD;
            end
            ST_POP_LD: begin
                cmd.op     = OP_POP_LOAD;
                state_next = ST_SINK_CHK;
            end
            ST_SINK_CHK: begin
                if (stat.has_left) begin
                    cmd.op     = OP_RD_CHILDREN;
                    state_next = ST_SINK_CMP;
                end else begin
                    cmd.op     = OP_WRITE_HOLE;
                    state_next = ST_TOP_RD;
                end
            end
            ST_SINK_CMP: begin
                cmd.op     = OP_SINK;
                state_next = stat.move_down ? ST_SINK_CHK : ST_TOP_RD;
            end
            ST_TOP_RD: begin
                cmd.op     = OP_RD_TOP;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
